[design/random_permutation_draw_defines.svh]
// Assertion macros for the random permutation draw block.
`ifndef RANDOM_PERMUTATION_DRAW_DEFINES_SVH
`define RANDOM_PERMUTATION_DRAW_DEFINES_SVH

`ifndef SYNTHESIS
`define RPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpd assertion failed");
`define RPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpd assertion failed");
`else
`define RPD_ASSERT_IMP(lbl, ante, cons)
`define RPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/rpd_pkg.sv]
// Shared types and constants for the random permutation draw block.
package rpd_pkg;

  localparam int RND_W     = 16;
  localparam int STEP_W    = 4;
  localparam int OUT_ID_W  = 6;
  localparam int CFG_W     = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFILL,
    ST_MOD,
    ST_PICK
  } rpd_state_t;

  typedef struct packed {
    logic refill;
    logic shift;
  } rpd_cell_ctrl_t;

endpackage

[design/rpd_mod.sv]
// Bit-serial restoring remainder unit: random value modulo pool count.
module rpd_mod import rpd_pkg::*; #(
  parameter int CW  = 7,
  parameter int IDW = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [CW-1:0]    divisor,
  output logic             done,
  output logic [IDW-1:0]   result
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [RND_W-1:0]  rnd;
  logic [CW-1:0]     div;
  logic [CW-1:0]     rem;
  logic [CW:0]       trial;

  assign trial  = {rem, rnd[RND_W-1]};
  assign result = rem[IDW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(RND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rnd <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (busy) begin
      rnd <= {rnd[RND_W-2:0], 1'b0};
      if (trial >= {1'b0, div}) begin
        rem <= CW'(trial - {1'b0, div});
      end else begin
        rem <= trial[CW-1:0];
      end
    end
  end

endmodule

[design/rpd_cell.sv]
// One pool cell: holds an identifier, refills to its own index, takes its neighbor's on removal.
module rpd_cell import rpd_pkg::*; #(
  parameter int IDW   = 6,
  parameter int INDEX = 0
) (
  input  logic           clk,
  input  rpd_cell_ctrl_t ctrl,
  input  logic [IDW-1:0] slot,
  input  logic [IDW-1:0] next_id,
  output logic [IDW-1:0] id,
  output logic [IDW-1:0] sel_id
);

  localparam logic [IDW-1:0] MY_INDEX = IDW'(INDEX);

  assign sel_id = (slot == MY_INDEX) ? id : '0;

  always_ff @(posedge clk) begin
    if (ctrl.refill) begin
      id <= MY_INDEX;
    end else if (ctrl.shift && (MY_INDEX >= slot)) begin
      id <= next_id;
    end
  end

endmodule

[design/random_permutation_draw.sv]
// Top level of the random permutation draw block.
//
// Deals a random permutation of identifiers 0 .. deck_size-1, one per input
// transfer. Slave stream: s_axis_tdata carries random_value, s_axis_tuser
// carries restart (refill the pool before this draw). Master stream:
// m_axis_tdata carries chosen_id, m_axis_tlast marks the draw that empties
// the pool. deck_size is written through cfg_we/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce it. It takes
// effect at the next refill (zero acts as 1, values above MAX_IDS saturate).
// Each draw runs the bit-serial remainder unit, latches the slot, then picks
// and shifts the cell row; when the pool is refilled, a refill of the cell
// row comes first. s_axis_tready stays low from the input transfer until the
// pick, so a new draw is not taken before the previous one is picked.
// The result sits in an output register; the next input transfer is taken
// while it waits. If the receiver stalls, the following draw holds in its
// pick step until the output register frees up.
// Reset sets deck_size to 52 and empties the pool, so the first draw refills;
// s_axis_tready is low while reset is held.
`include "random_permutation_draw_defines.svh"

module random_permutation_draw import rpd_pkg::*; #(
  parameter int MAX_IDS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // [15:0] random_value
  input  logic             s_axis_tuser,  // [0] restart
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [5:0] chosen_id, [7:6] zero
  output logic             m_axis_tlast
);

  localparam int IDW = $clog2(MAX_IDS);
  localparam int CW  = $clog2(MAX_IDS + 1);
  localparam int EW  = (CW > CFG_W) ? CW : CFG_W;

  rpd_state_t       state, state_next;
  logic [CFG_W-1:0] deck_size;
  logic [CW-1:0]    remaining, remaining_next;
  logic [RND_W-1:0] rnd;
  logic [RND_W-1:0] mod_dividend;
  logic [EW-1:0]    deck_ext;
  logic [CW-1:0]    eff_size;
  logic             accept, need_refill, advance;
  logic             mod_start, mod_done;
  logic [CW-1:0]    mod_divisor;
  logic [IDW-1:0]   slot, mod_result;
  rpd_cell_ctrl_t   cell_ctrl;
  logic [IDW-1:0]   pool_id [MAX_IDS];
  logic [IDW-1:0]   pool_sel [MAX_IDS];
  logic [IDW-1:0]   picked;
  logic [IDW+OUT_ID_W-1:0] picked_wide;

  assign accept       = s_axis_tvalid && s_axis_tready;
  assign deck_ext     = EW'(deck_size);
  assign eff_size     = (deck_ext == '0) ? CW'(1) :
                        (deck_ext > EW'(MAX_IDS)) ? CW'(MAX_IDS) : CW'(deck_ext);
  assign need_refill  = s_axis_tuser || (remaining == '0);
  assign advance      = (state == ST_PICK) && (!m_axis_tvalid || m_axis_tready);
  assign mod_divisor  = (state == ST_REFILL) ? eff_size : remaining;
  assign mod_dividend = accept ? s_axis_tdata : rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      deck_size <= CFG_W'(52);
    end else if (cfg_we) begin
      deck_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= '0;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
    end
  end

  always_comb begin
    state_next     = state;
    remaining_next = remaining;
    s_axis_tready  = 1'b0;
    mod_start      = 1'b0;
    cell_ctrl      = '0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = !rst;
        if (accept) begin
          if (need_refill) begin
            state_next = ST_REFILL;
          end else begin
            mod_start  = 1'b1;
            state_next = ST_MOD;
          end
        end
      end
      ST_REFILL: begin
        cell_ctrl.refill = 1'b1;
        remaining_next   = eff_size;
        mod_start        = 1'b1;
        state_next       = ST_MOD;
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (advance) begin
          cell_ctrl.shift = 1'b1;
          remaining_next  = remaining - 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rnd <= s_axis_tdata;
    end
    if (mod_done) begin
      slot <= mod_result;
    end
  end

  rpd_mod #(
    .CW  (CW),
    .IDW (IDW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .result   (mod_result)
  );

  for (genvar i = 0; i < MAX_IDS; i++) begin : g_cell
    rpd_cell #(
      .IDW   (IDW),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .slot    (slot),
      .next_id ((i == MAX_IDS - 1) ? pool_id[i] : pool_id[(i + 1) % MAX_IDS]),
      .id      (pool_id[i]),
      .sel_id  (pool_sel[i])
    );
  end

  always_comb begin
    picked = '0;
    for (int i = 0; i < MAX_IDS; i++) begin
      picked = picked | pool_sel[i];
    end
  end

  assign picked_wide = {{OUT_ID_W{1'b0}}, picked};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {2'b00, picked_wide[OUT_ID_W-1:0]};
      m_axis_tlast <= (remaining == CW'(1));
    end
  end

  `RPD_ASSERT_IMP(a_remaining_range, 1'b1, remaining <= CW'(MAX_IDS))
  `RPD_ASSERT_IMP(a_slot_in_pool, mod_done, mod_result < remaining)
  `RPD_ASSERT_NEXT(a_pick_loads_output, advance, m_axis_tvalid && (state == ST_IDLE))
  `RPD_ASSERT_IMP(a_refill_on_restart, accept && s_axis_tuser, state_next == ST_REFILL)

endmodule

[tb/testbench.sv]
// Self-checking testbench for the random permutation draw block.
module testbench;
  import rpd_pkg::*;

  localparam int POOL_DEPTH = 64;

  typedef struct packed {
    logic [OUT_ID_W-1:0] id;
    logic                last;
  } draw_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata;   // [15:0] random_value
  logic             s_axis_tuser;   // [0] restart
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;   // [5:0] chosen_id, [7:6] zero
  logic             m_axis_tlast;

  logic [OUT_ID_W-1:0] pool_model [POOL_DEPTH];
  int unsigned         ids_left;
  logic [CFG_W-1:0]    deck_model;
  draw_t               expected_draws [$];

  bit idle_en;
  bit stall_en;
  int mismatch_count;
  int draws_sent;
  int restarts_sent;
  int perms_done;
  int deck_writes;

  always #5 clk = ~clk;

  random_permutation_draw #(.MAX_IDS(POOL_DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic void refill_pool(input int unsigned n);
    for (int i = 0; i < POOL_DEPTH; i++) pool_model[i] = i[OUT_ID_W-1:0];
    ids_left = n;
  endfunction

  function automatic void predict_draw(input logic [RND_W-1:0] rnd, input logic restart);
    int unsigned n;
    int unsigned slot;
    draw_t d;
    if (restart || ids_left == 0 || ids_left > POOL_DEPTH) begin
      if (deck_model == 0) n = 1;
      else if (deck_model > POOL_DEPTH) n = POOL_DEPTH;
      else n = deck_model;
      refill_pool(n);
    end
    slot = rnd % ids_left;
    d.id = pool_model[slot];
    for (int j = slot; j + 1 < ids_left; j++) pool_model[j] = pool_model[j + 1];
    ids_left--;
    d.last = (ids_left == 0);
    expected_draws.push_back(d);
  endfunction

  task automatic send_draw(input logic [RND_W-1:0] rnd, input logic restart);
    if (idle_en && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rnd;
    s_axis_tuser  <= restart;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_draw(rnd, restart);
    draws_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_deck_size(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    deck_model = value;
    deck_writes++;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_deck_size();
    case ($urandom_range(9))
      0:       return CFG_W'(POOL_DEPTH);
      1:       return CFG_W'($urandom_range(POOL_DEPTH + 1, 127));
      2:       return '0;
      default: return CFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic test_directed_cases();
    send_draw(16'h0000, 1'b0);
    send_draw(16'hFFFF, 1'b0);
    send_draw(16'h8000, 1'b1);
    send_draw(16'h0001, 1'b0);
    // hold the partly drawn pool across a deck size change
    write_deck_size(7'd1);
    send_draw(16'h1234, 1'b0);
    send_draw(16'h0000, 1'b1);
    send_draw(16'hFFFF, 1'b0);
    write_deck_size(7'd0);
    send_draw(16'hFFFF, 1'b1);
    send_draw(16'h0000, 1'b0);
    write_deck_size(7'd127);
    send_draw(16'hFFFF, 1'b1);
    send_draw(16'h003F, 1'b0);
    write_deck_size(7'd64);
    send_draw(16'hFFFF, 1'b1);
    send_draw(16'h0000, 1'b0);
    write_deck_size(7'd65);
    send_draw(16'h7FFF, 1'b1);
    write_deck_size(7'd2);
    send_draw(16'hFFFF, 1'b1);
    send_draw(16'h0000, 1'b0);
    send_draw(16'h5555, 1'b0);
    send_draw(16'hAAAA, 1'b1);
  endtask

  task automatic test_full_permutations();
    int sizes [7] = '{1, 2, 3, 4, 7, 16, 64};
    bit first;
    foreach (sizes[k]) begin
      write_deck_size(CFG_W'(sizes[k]));
      first = 1'b1;
      do begin
        send_draw(RND_W'($urandom_range(16'hFFFF)), first);
        first = 1'b0;
      end while (ids_left != 0);
    end
  endtask

  task automatic test_random_draws();
    for (int phase = 0; phase < 8; phase++) begin
      write_deck_size(pick_deck_size());
      repeat (60) send_draw(RND_W'($urandom_range(16'hFFFF)), $urandom_range(99) < 6);
    end
  endtask

  task automatic test_back_to_back();
    idle_en  = 1'b0;
    stall_en = 1'b0;
    write_deck_size(CFG_W'($urandom_range(3, 10)));
    repeat (150) send_draw(RND_W'($urandom_range(16'hFFFF)), $urandom_range(99) < 4);
    wait_drained();
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= !stall_en || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin : check_results
    draw_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_draws.size() == 0) begin
        $error("result with no pending draw: chosen_id %0d", m_axis_tdata[OUT_ID_W-1:0]);
        mismatch_count++;
      end else begin
        want = expected_draws.pop_front();
        if (m_axis_tdata[OUT_ID_W-1:0] !== want.id) begin
          $error("chosen_id: expected %0d, got %0d", want.id, m_axis_tdata[OUT_ID_W-1:0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tdata[7:OUT_ID_W] !== '0) begin
          $error("tdata pad: expected 0, got %0d", m_axis_tdata[7:OUT_ID_W]);
          mismatch_count++;
        end
        if (want.last) perms_done++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    idle_en       = 1'b1;
    stall_en      = 1'b1;
    deck_model    = 7'd52;
    refill_pool(0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_full_permutations();
    test_random_draws();
    test_back_to_back();
    wait_drained();
    repeat (25) @(posedge clk);
    $display("Covered %0d draws (%0d with restart), %0d complete permutations.",
             draws_sent, restarts_sent, perms_done);
    $display("Deck size written %0d times, including zero, 1, 64 and out-of-range values.",
             deck_writes);
    if (mismatch_count == 0 && expected_draws.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (expected_draws.size() != 0)
        $error("%0d expected draws never arrived", expected_draws.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/rpd_pkg.sv
design/rpd_mod.sv
design/rpd_cell.sv
design/random_permutation_draw.sv
tb/testbench.sv
